// File: hdl/pdsg_pkg.sv
// ----------------------------------------------------------------------------
// pdsg_pkg: shared types and constants for the particle disc splat grid
// Payload structs, configuration register indexes, item kinds and the
// pixel-centre rounding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pdsg_pkg;

  // signed width of pixel coordinates before clipping
  localparam int CW = 36;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QTY_SELECT  = 2'd2;

  localparam logic KIND_SPLAT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic QTY_DENSITY = 1'b0;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] smooth_len;
    logic        [31:0] density;
    logic        [31:0] temperature;
    logic        [7:0]  read_row;
    logic        [7:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        pixel_empty;
  } out_item_t;

  // trunc((+/-mag + half) / 2^32), rounding toward zero
  function automatic logic signed [CW-1:0] centre_idx(logic [63:0] mag, logic neg,
                                                      logic [63:0] half);
    logic [63:0]          t;
    logic signed [CW-1:0] v;
    if (!neg) begin
      t = mag + half;
      v = $signed({{(CW-32){1'b0}}, t[63:32]});
    end else if (mag <= half) begin
      t = half - mag;
      v = $signed({{(CW-32){1'b0}}, t[63:32]});
    end else begin
      t = mag - half;
      v = -$signed({{(CW-32){1'b0}}, t[63:32]});
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/particle_disc_splat_grid.sv
// ----------------------------------------------------------------------------
// particle_disc_splat_grid: top-hat particle splatting onto a pixel grid
// Splats particles as discs into a weighted-sum grid and a weight grid and
// returns density-weighted pixel averages on request.
// ----------------------------------------------------------------------------
//
//  channel | ports                        | moves
//  --------+------------------------------+------------------------------------
//  in      | in_valid/in_ready/in_data    | splat or read transaction
//  out     | out_valid/out_ready/out_data | averaged pixel, one per read
//  cfg     | cfg_we/cfg_index/cfg_wdata   | register write, no handshake
//
//  Flow: splat setup is dominated by the square root; the pixel loop then
//  walks the clipped bounding box of the disc row by row, and the one
//  shared multiplier and the grid memory port set its pace.
//  A particle that does not cut the slice is dropped at the check.
//  A read off the grid is answered empty without the grid; other reads
//  use the divider when the weight is nonzero (which saturates an oversized quotient).
//  Reset: a clearing pass zeroes the grid, one entry a cycle, 4**ceil(log2
//  MAX_SIDE) entries (65536 by default); in_ready stays low meanwhile.
//  Stalls: a finished read waits in the output register; the sequencer
//  holds before loading a second result until the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_disc_splat_grid
  import pdsg_pkg::*;
#(
  parameter int MAX_SIDE = 256,
  parameter int ACC_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  localparam int IW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int AW = 2 * IW;
  localparam int DW = 2 * ACC_BITS;
  localparam logic [63:0] ACC_MAX64 = {64{1'b1}} >> (64 - ACC_BITS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHK, S_HH, S_ZZ, S_ROOT, S_RAD, S_CX, S_CY, S_R2,
    S_PROD, S_ROW_MUL, S_ROW_SUB, S_PIX_MUL, S_PIX_CHK, S_RD_MEM, S_RD_DIV,
    S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [8:0]  grid_side_r;
  logic [31:0] coord_scale_r;
  logic        qty_sel_r;

  // item and working registers
  in_item_t             item_r;
  logic [31:0]          az_r;
  logic [63:0]          hh_r;
  logic [31:0]          r_r;
  logic [63:0]          r2_r;
  logic [63:0]          prod_r;
  logic [63:0]          rem_r;
  logic signed [CW-1:0] ic_r;
  logic signed [CW-1:0] jc_r;
  logic [IW-1:0]        i_r;
  logic [IW-1:0]        j_r;
  logic [IW-1:0]        ihi_r;
  logic [IW-1:0]        jlo_r;
  logic [IW-1:0]        jhi_r;
  logic [AW-1:0]        clr_r;
  out_item_t            res_r;
  out_item_t            out_data_r;
  logic                 out_valid_r;

  // side in use, clamped to 1..MAX_SIDE
  logic [SW-1:0]        side;
  logic [63:0]          half;
  logic signed [CW-1:0] side_m1;

  always_comb begin
    if (grid_side_r == 9'd0) begin
      side = SW'(1);
    end else if (32'(grid_side_r) > 32'(MAX_SIDE)) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(grid_side_r);
    end
  end

  assign half    = 64'(side) << 31;
  assign side_m1 = $signed(CW'(side)) - $signed(CW'(1));

  // magnitudes of the signed inputs
  logic [31:0] mag_x, mag_y, mag_z, qty;
  assign mag_x = item_r.pos_x[31] ? 32'(-item_r.pos_x) : 32'(item_r.pos_x);
  assign mag_y = item_r.pos_y[31] ? 32'(-item_r.pos_y) : 32'(item_r.pos_y);
  assign mag_z = item_r.pos_z[31] ? 32'(-item_r.pos_z) : 32'(item_r.pos_z);
  assign qty   = (qty_sel_r == QTY_DENSITY) ? item_r.density : item_r.temperature;

  // pixel offsets from the centre, never beyond r
  logic signed [CW-1:0] di, dj;
  logic [31:0]          adi, adj;
  assign di  = $signed({{(CW-IW){1'b0}}, i_r}) - ic_r;
  assign dj  = $signed({{(CW-IW){1'b0}}, j_r}) - jc_r;
  assign adi = di[CW-1] ? 32'(-di) : 32'(di);
  assign adj = dj[CW-1] ? 32'(-dj) : 32'(dj);

  // clipped bounding box of the disc
  logic signed [CW-1:0] r_s, ilo_c, ihi_c, jlo_c, jhi_c;
  logic                 box_empty;

  always_comb begin
    r_s   = $signed({{(CW-32){1'b0}}, r_r});
    ilo_c = ic_r - r_s;
    ihi_c = ic_r + r_s;
    jlo_c = jc_r - r_s;
    jhi_c = jc_r + r_s;
    if (ilo_c < 0) ilo_c = '0;
    if (jlo_c < 0) jlo_c = '0;
    if (ihi_c > side_m1) ihi_c = side_m1;
    if (jhi_c > side_m1) jhi_c = side_m1;
    box_empty = (ilo_c > ihi_c) || (jlo_c > jhi_c);
  end

  // square root handshake and result
  logic        root_start, root_done;
  logic [31:0] root;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CHK:     begin mul_a = item_r.smooth_len; mul_b = item_r.smooth_len; end
      S_HH:      begin mul_a = az_r;              mul_b = az_r;              end
      S_ROOT:    begin mul_a = root;              mul_b = coord_scale_r;     end
      S_RAD:     begin mul_a = mag_x;             mul_b = coord_scale_r;     end
      S_CX:      begin mul_a = mag_y;             mul_b = coord_scale_r;     end
      S_CY:      begin mul_a = r_r;               mul_b = r_r;               end
      S_R2:      begin mul_a = qty;               mul_b = item_r.density;    end
      S_ROW_MUL: begin mul_a = adi;               mul_b = adi;               end
      S_PIX_MUL: begin mul_a = adj;               mul_b = adj;               end
      default:   begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  pdsg_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  // square root of h^2 - z^2
  assign root_start = (state_r == S_ZZ);

  pdsg_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (hh_r - mul_p),
    .done_r   (root_done),
    .root     (root)
  );

  // grid memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic [ACC_BITS-1:0] cell_sum, cell_wt;
  logic          in_disc;

  assign cell_sum = mem_rdata[DW-1:ACC_BITS];
  assign cell_wt  = mem_rdata[ACC_BITS-1:0];
  assign in_disc  = (mul_p <= rem_r);

  function automatic logic [ACC_BITS-1:0] sat_add(logic [ACC_BITS-1:0] a, logic [63:0] b);
    logic [ACC_BITS-1:0] bc;
    logic [ACC_BITS:0]   s;
    bc = (b > ACC_MAX64) ? ACC_BITS'(ACC_MAX64) : ACC_BITS'(b);
    s  = {1'b0, a} + {1'b0, bc};
    return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
  endfunction

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {i_r, j_r};
    mem_wdata = {sat_add(cell_sum, prod_r), sat_add(cell_wt, 64'(item_r.density))};
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (state_r == S_PIX_CHK && in_disc) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state_r == S_CHK) ?
                     {IW'(item_r.read_row), IW'(item_r.read_col)} : {i_r, j_r};

  pdsg_grid_mem #(
    .AW (AW),
    .DW (DW)
  ) u_grid (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  // pixel average divider
  logic        div_start, div_done;
  logic [31:0] div_quo;

  assign div_start = (state_r == S_RD_MEM) && (cell_wt != '0);

  pdsg_div #(
    .ACC_BITS (ACC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (cell_sum),
    .den    (cell_wt),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic read_off_grid;
  assign read_off_grid = (32'(item_r.read_row) >= 32'(side)) ||
                         (32'(item_r.read_col) >= 32'(side));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
      grid_side_r   <= 9'd256;
      coord_scale_r <= 32'd65536;
      qty_sel_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_SIDE:   grid_side_r   <= cfg_wdata[8:0];
          REG_COORD_SCALE: coord_scale_r <= cfg_wdata;
          REG_QTY_SELECT:  qty_sel_r     <= cfg_wdata[0];
          default:         ;
        endcase
      end

      // drop the taken result unless a new one is loaded in its place
      if (out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == {AW{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          az_r <= mag_z;
          if (item_r.kind == KIND_READ) begin
            if (read_off_grid) begin
              res_r   <= '{pixel_value: '0, pixel_empty: 1'b1};
              state_r <= S_EMIT;
            end else begin
              state_r <= S_RD_MEM;
            end
          end else if (mag_z >= item_r.smooth_len) begin
            // drop particles that do not cut the slice
            state_r <= S_IDLE;
          end else begin
            state_r <= S_HH;
          end
        end
        S_HH: begin
          hh_r    <= mul_p;
          state_r <= S_ZZ;
        end
        S_ZZ: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            state_r <= S_RAD;
          end
        end
        S_RAD: begin
          r_r     <= mul_p[63:32];
          state_r <= S_CX;
        end
        S_CX: begin
          ic_r    <= centre_idx(mul_p, item_r.pos_x[31], half);
          state_r <= S_CY;
        end
        S_CY: begin
          // y axis is inverted: positive y maps to columns below the centre index
          jc_r    <= centre_idx(mul_p, !item_r.pos_y[31] && (item_r.pos_y != '0), half);
          state_r <= S_R2;
        end
        S_R2: begin
          r2_r    <= mul_p;
          state_r <= S_PROD;
        end
        S_PROD: begin
          prod_r <= mul_p;
          i_r    <= ilo_c[IW-1:0];
          ihi_r  <= ihi_c[IW-1:0];
          jlo_r  <= jlo_c[IW-1:0];
          jhi_r  <= jhi_c[IW-1:0];
          state_r <= box_empty ? S_IDLE : S_ROW_MUL;
        end
        S_ROW_MUL: begin
          state_r <= S_ROW_SUB;
        end
        S_ROW_SUB: begin
          rem_r   <= r2_r - mul_p;
          j_r     <= jlo_r;
          state_r <= S_PIX_MUL;
        end
        S_PIX_MUL: begin
          state_r <= S_PIX_CHK;
        end
        S_PIX_CHK: begin
          // advance across the row, then down to the next row
          if (j_r == jhi_r) begin
            if (i_r == ihi_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + IW'(1);
              state_r <= S_ROW_MUL;
            end
          end else begin
            j_r     <= j_r + IW'(1);
            state_r <= S_PIX_MUL;
          end
        end
        S_RD_MEM: begin
          if (cell_wt == '0) begin
            res_r   <= '{pixel_value: '0, pixel_empty: 1'b1};
            state_r <= S_EMIT;
          end else begin
            state_r <= S_RD_DIV;
          end
        end
        S_RD_DIV: begin
          if (div_done) begin
            res_r   <= '{pixel_value: div_quo, pixel_empty: 1'b0};
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_pixel_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PIX_CHK) |-> (i_r <= ihi_r && j_r <= jhi_r))
    else $error("pixel walk left the clipped box");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !out_valid_r) |=> out_valid_r)
    else $error("result not loaded into a free output register");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHK))
    else $error("accepted transaction did not start the sequencer");

  a_write_in_disc: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_CLEAR) |-> (state_r == S_PIX_CHK && mul_p <= rem_r))
    else $error("grid written outside the disc");

endmodule

`default_nettype wire

// File: hdl/pdsg_mul.sv
// ----------------------------------------------------------------------------
// pdsg_mul: shared 32x32 unsigned multiplier
// One product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pdsg_mul (
  input  wire logic        clk,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic      [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

endmodule

`default_nettype wire

// File: hdl/pdsg_isqrt.sv
// ----------------------------------------------------------------------------
// pdsg_isqrt: iterative integer square root
// floor(sqrt(n)) of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdsg_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done_r,
  output logic      [31:0] root
);

  logic [63:0] n_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign root  = res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= radicand;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (n_r >= trial) begin
          n_r   <= n_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/pdsg_div.sv
// ----------------------------------------------------------------------------
// pdsg_div: iterative restoring divider
// 32-bit saturated quotient of two accumulator words, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdsg_div #(
  parameter int ACC_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [ACC_BITS-1:0] num,
  input  wire logic [ACC_BITS-1:0] den,
  output logic                     done_r,
  output logic [31:0]              quo_r
);

  logic [ACC_BITS-1:0] rem_r;
  logic [ACC_BITS-1:0] den_r;
  logic [31:0]         low_r;
  logic [4:0]          cnt_r;
  logic                busy_r;
  logic [ACC_BITS-1:0] hi;
  logic [ACC_BITS:0]   rem2;
  logic                ge;

  assign hi   = num >> 32;
  assign rem2 = {rem_r, low_r[31]};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        if (hi >= den) begin
          // quotient does not fit: saturate
          quo_r  <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r  <= hi;
          low_r  <= num[31:0];
          quo_r  <= '0;
          cnt_r  <= '0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? ACC_BITS'(rem2 - {1'b0, den_r}) : rem2[ACC_BITS-1:0];
        quo_r <= {quo_r[30:0], ge};
        low_r <= low_r << 1;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/pdsg_grid_mem.sv
// ----------------------------------------------------------------------------
// pdsg_grid_mem: accumulator grid storage
// One write port and one registered read port; each word holds the
// weighted sum above the weight.
// ----------------------------------------------------------------------------
`default_nettype none

module pdsg_grid_mem #(
  parameter int AW = 16,
  parameter int DW = 128
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire
